// File: design/qph_pkg.sv
// Shared types and constants of the quadratic probing hash table.
`default_nettype none

package qph_pkg;

    localparam int TABLE_SLOTS_DEF = 101;
    localparam int PROBE_LIMIT_DEF = 20;
    localparam int KEY_BYTES_DEF   = 8;

    localparam int HASH_MUL  = 19;
    localparam int PROBE_LIN = 23;

    localparam int KEY_W      = 64;
    localparam int LEN_W      = 4;
    localparam int IDX_W      = 7;
    localparam int SLOT_OUT_W = 7;
    localparam int ENT_W      = 7;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_READ   = 2'd3
    } cmd_t;

    typedef struct packed {
        logic             valid;
        logic [LEN_W-1:0] len;
        logic [KEY_W-1:0] key;
    } entry_t;

endpackage

`default_nettype wire

// File: design/qph_if.sv
// Request and response channel interfaces of the hash table.
`default_nettype none

interface qph_in_if;
    logic                        valid;
    logic                        ready;
    qph_pkg::cmd_t               cmd;
    logic [qph_pkg::KEY_W-1:0]   key_chars;
    logic [qph_pkg::LEN_W-1:0]   key_len;
    logic [qph_pkg::IDX_W-1:0]   slot_index;

    modport source (output valid, cmd, key_chars, key_len, slot_index, input ready);
    modport sink   (input valid, cmd, key_chars, key_len, slot_index, output ready);
endinterface

interface qph_out_if;
    logic                           valid;
    logic                           ready;
    logic                           ok;
    logic [qph_pkg::SLOT_OUT_W-1:0] slot;
    logic [qph_pkg::KEY_W-1:0]      key_out;
    logic [qph_pkg::LEN_W-1:0]      key_len_out;
    logic [qph_pkg::ENT_W-1:0]      entry_count;

    modport source (output valid, ok, slot, key_out, key_len_out, entry_count, input ready);
    modport sink   (input valid, ok, slot, key_out, key_len_out, entry_count, output ready);
endinterface

`default_nettype wire

// File: design/qph_hash.sv
// Home slot unit: weighted byte sum, scale, then remainder by reciprocal multiplication.
`default_nettype none

module qph_hash #(
    parameter int TABLE_SLOTS = qph_pkg::TABLE_SLOTS_DEF,
    parameter int KEY_BYTES   = qph_pkg::KEY_BYTES_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [qph_pkg::KEY_W-1:0]      key,
    output logic                                done,
    output logic [$clog2(TABLE_SLOTS)-1:0]      home
);
    import qph_pkg::*;

    localparam int SLOT_W  = $clog2(TABLE_SLOTS);
    localparam int SUM_MAX = 255 * KEY_BYTES * (KEY_BYTES + 1) / 2;
    localparam int SUM_W   = $clog2(SUM_MAX + 1);
    localparam int PROD_W  = $clog2(SUM_MAX * HASH_MUL + 1);
    localparam int RCP_SH  = PROD_W + SLOT_W;
    localparam int RCP_W   = PROD_W + 1;
    localparam int MUL_W   = PROD_W + RCP_W;
    localparam int QUO_W   = MUL_W - RCP_SH;
    localparam longint RCP_VAL = ((longint'(1) << RCP_SH) + longint'(TABLE_SLOTS) - 1)
                                 / longint'(TABLE_SLOTS);
    localparam logic [RCP_W-1:0]  RCP     = RCP_W'(RCP_VAL);
    localparam logic [PROD_W-1:0] SLOTS_P = PROD_W'(TABLE_SLOTS);

    typedef enum logic [1:0] {H_IDLE, H_MUL, H_QUO, H_REM} hstate_t;

    hstate_t             hstate_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [PROD_W-1:0]   dvd_reg;
    logic [QUO_W-1:0]    quo_reg;
    logic [SLOT_W-1:0]   rem_reg;
    logic                done_reg;

    logic [SUM_W-1:0]    sum_comb;
    logic [MUL_W-1:0]    rcp_prod;
    logic [PROD_W-1:0]   rem_full;

    always_comb
    begin
        sum_comb = '0;
        for (int i = 0; i < KEY_BYTES; i++)
        begin
            sum_comb = sum_comb + SUM_W'(key[8*i +: 8]) * SUM_W'(i + 1);
        end
    end

    assign rcp_prod = MUL_W'(dvd_reg) * MUL_W'(RCP);
    assign rem_full = dvd_reg - PROD_W'(quo_reg) * SLOTS_P;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hstate_reg <= H_IDLE;
            sum_reg    <= '0;
            dvd_reg    <= '0;
            quo_reg    <= '0;
            rem_reg    <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= (hstate_reg == H_REM);
            unique case (hstate_reg)
                H_IDLE:
                begin
                    if (start)
                    begin
                        sum_reg    <= sum_comb;
                        hstate_reg <= H_MUL;
                    end
                end
                H_MUL:
                begin
                    dvd_reg    <= PROD_W'(sum_reg) * PROD_W'(HASH_MUL);
                    hstate_reg <= H_QUO;
                end
                H_QUO:
                begin
                    quo_reg    <= rcp_prod[MUL_W-1 -: QUO_W];
                    hstate_reg <= H_REM;
                end
                H_REM:
                begin
                    rem_reg    <= rem_full[SLOT_W-1:0];
                    hstate_reg <= H_IDLE;
                end
                default:
                begin
                    hstate_reg <= H_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign home = rem_reg;

endmodule

`default_nettype wire

// File: design/quadratic_probe_hash_table.sv
// Top level of the open-addressed hash table with quadratic probing.
`default_nettype none

// Holds up to TABLE_SLOTS short byte-string keys in one slot memory (valid mark, length,
// key bytes) with a single registered read port. After reset the block sweeps the memory
// clear, one slot a cycle, before the first request is taken. Requests are handled one
// at a time. A read of a slot in range takes its result from the registered read port.
// Add, delete and look up first form the home slot (weighted byte sum, scale, reciprocal
// quotient, remainder), then probe the memory one slot per cycle in a read pipeline,
// stopping at the first empty slot, at a match or after PROBE_LIMIT probes. Add inserts
// at the empty slot that ends its search. A result is held in an output register, and a
// new request is taken while it waits.
module quadratic_probe_hash_table #(
    parameter int TABLE_SLOTS = qph_pkg::TABLE_SLOTS_DEF,
    parameter int PROBE_LIMIT = qph_pkg::PROBE_LIMIT_DEF,
    parameter int KEY_BYTES   = qph_pkg::KEY_BYTES_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    qph_in_if.sink    req,
    qph_out_if.source rsp
);
    import qph_pkg::*;

    localparam int SLOT_W = $clog2(TABLE_SLOTS);
    localparam int CNT_W  = $clog2(PROBE_LIMIT + 1);
    localparam int VC_W   = $clog2(TABLE_SLOTS + 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);
    localparam logic [SLOT_W:0]   SLOTS_X   = (SLOT_W + 1)'(TABLE_SLOTS);
    localparam logic [SLOT_W-1:0] DELTA0    = SLOT_W'((1 + PROBE_LIN) % TABLE_SLOTS);
    localparam logic [SLOT_W-1:0] STEP2     = SLOT_W'(2 % TABLE_SLOTS);
    localparam logic [CNT_W-1:0]  PROBES    = CNT_W'(PROBE_LIMIT);
    localparam logic [CNT_W-1:0]  LAST_PRB  = CNT_W'(PROBE_LIMIT - 1);

    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_HASH, S_PROBE, S_RDWAIT, S_DONE} state_t;

    entry_t mem [TABLE_SLOTS];
    entry_t rd_data_reg;

    state_t                 state_reg;
    logic [SLOT_W-1:0]      clr_addr_reg;
    cmd_t                   cmd_reg;
    logic [KEY_W-1:0]       key_reg;
    logic [LEN_W-1:0]       len_reg;
    logic [SLOT_W-1:0]      pos_reg;
    logic [SLOT_W-1:0]      delta_reg;
    logic [CNT_W-1:0]       issue_cnt_reg;
    logic [SLOT_W-1:0]      chk_pos_reg;
    logic                   chk_vld_reg;
    logic                   chk_last_reg;
    logic                   res_ok_reg;
    logic [SLOT_W-1:0]      res_slot_reg;
    logic [KEY_W-1:0]       res_key_reg;
    logic [LEN_W-1:0]       res_len_reg;
    logic                   wr_pend_reg;
    logic [VC_W-1:0]        count_reg;
    logic                   out_vld_reg;
    logic                   out_ok_reg;
    logic [SLOT_OUT_W-1:0]  out_slot_reg;
    logic [KEY_W-1:0]       out_key_reg;
    logic [LEN_W-1:0]       out_len_reg;
    logic [ENT_W-1:0]       out_cnt_reg;

    logic [LEN_W-1:0]       len_eff;
    logic [KEY_W-1:0]       key_m;
    logic                   req_fire;
    logic                   out_free;
    logic                   idx_ok;
    logic                   hash_start;
    logic                   hash_done;
    logic [SLOT_W-1:0]      hash_home;
    logic [SLOT_W-1:0]      rd_addr;
    logic                   wr_en;
    logic [SLOT_W-1:0]      wr_addr;
    entry_t                 wr_data;
    logic [SLOT_W:0]        pos_sum;
    logic [SLOT_W-1:0]      pos_adv;
    logic [SLOT_W:0]        delta_sum;
    logic [SLOT_W-1:0]      delta_adv;
    logic                   hit;
    logic                   finish;
    logic [VC_W-1:0]        count_next;

    assign len_eff = (req.key_len > LEN_W'(KEY_BYTES)) ? LEN_W'(KEY_BYTES) : req.key_len;

    always_comb
    begin
        for (int i = 0; i < KEY_W / 8; i++)
        begin
            key_m[8*i +: 8] = (LEN_W'(i) < len_eff) ? req.key_chars[8*i +: 8] : 8'd0;
        end
    end

    assign req.ready  = (state_reg == S_IDLE);
    assign req_fire   = req.valid && req.ready;
    assign out_free   = !out_vld_reg || rsp.ready;
    assign idx_ok     = (32'(req.slot_index) < 32'(TABLE_SLOTS));
    assign hash_start = req_fire && (req.cmd != CMD_READ);

    qph_hash #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .KEY_BYTES   (KEY_BYTES)
    ) u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hash_start),
        .key   (key_m),
        .done  (hash_done),
        .home  (hash_home)
    );

    assign pos_sum   = {1'b0, pos_reg} + {1'b0, delta_reg};
    assign pos_adv   = (pos_sum >= SLOTS_X) ? SLOT_W'(pos_sum - SLOTS_X) : pos_sum[SLOT_W-1:0];
    assign delta_sum = {1'b0, delta_reg} + {1'b0, STEP2};
    assign delta_adv = (delta_sum >= SLOTS_X) ? SLOT_W'(delta_sum - SLOTS_X)
                                              : delta_sum[SLOT_W-1:0];

    assign hit = rd_data_reg.valid && (rd_data_reg.len == len_reg) &&
                 (rd_data_reg.key == key_reg);

    assign rd_addr = (state_reg == S_IDLE) ? SLOT_W'(req.slot_index) : pos_reg;
    assign finish  = (state_reg == S_DONE) && out_free;

    always_comb
    begin
        wr_en         = 1'b0;
        wr_addr       = res_slot_reg;
        wr_data.valid = (cmd_reg == CMD_ADD);
        wr_data.len   = len_reg;
        wr_data.key   = key_reg;
        if (state_reg == S_CLEAR)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_reg;
            wr_data = '0;
        end
        else if (finish && wr_pend_reg)
        begin
            wr_en = 1'b1;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (finish && wr_pend_reg)
        begin
            count_next = (cmd_reg == CMD_ADD) ? count_reg + 1'b1 : count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            cmd_reg       <= CMD_ADD;
            key_reg       <= '0;
            len_reg       <= '0;
            pos_reg       <= '0;
            delta_reg     <= '0;
            issue_cnt_reg <= '0;
            chk_pos_reg   <= '0;
            chk_vld_reg   <= 1'b0;
            chk_last_reg  <= 1'b0;
            res_ok_reg    <= 1'b0;
            res_slot_reg  <= '0;
            res_key_reg   <= '0;
            res_len_reg   <= '0;
            wr_pend_reg   <= 1'b0;
            count_reg     <= '0;
            out_vld_reg   <= 1'b0;
            out_ok_reg    <= 1'b0;
            out_slot_reg  <= '0;
            out_key_reg   <= '0;
            out_len_reg   <= '0;
            out_cnt_reg   <= '0;
        end
        else
        begin
            if (finish)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (rsp.valid && rsp.ready)
            begin
                out_vld_reg <= 1'b0;
            end

            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (clr_addr_reg == LAST_SLOT)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (req_fire)
                    begin
                        cmd_reg      <= req.cmd;
                        key_reg      <= key_m;
                        len_reg      <= len_eff;
                        chk_pos_reg  <= SLOT_W'(req.slot_index);
                        res_ok_reg   <= 1'b0;
                        res_slot_reg <= '0;
                        res_key_reg  <= '0;
                        res_len_reg  <= '0;
                        wr_pend_reg  <= 1'b0;
                        if (req.cmd != CMD_READ)
                        begin
                            state_reg <= S_HASH;
                        end
                        else if (idx_ok)
                        begin
                            state_reg <= S_RDWAIT;
                        end
                        else
                        begin
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_HASH:
                begin
                    if (hash_done)
                    begin
                        pos_reg       <= hash_home;
                        delta_reg     <= DELTA0;
                        issue_cnt_reg <= '0;
                        chk_vld_reg   <= 1'b0;
                        state_reg     <= S_PROBE;
                    end
                end
                S_PROBE:
                begin
                    if (issue_cnt_reg != PROBES)
                    begin
                        chk_pos_reg   <= pos_reg;
                        chk_vld_reg   <= 1'b1;
                        chk_last_reg  <= (issue_cnt_reg == LAST_PRB);
                        pos_reg       <= pos_adv;
                        delta_reg     <= delta_adv;
                        issue_cnt_reg <= issue_cnt_reg + 1'b1;
                    end
                    else
                    begin
                        chk_vld_reg <= 1'b0;
                    end

                    if (chk_vld_reg)
                    begin
                        if (!rd_data_reg.valid)
                        begin
                            state_reg <= S_DONE;
                            if (cmd_reg == CMD_ADD)
                            begin
                                res_ok_reg   <= 1'b1;
                                res_slot_reg <= chk_pos_reg;
                                wr_pend_reg  <= 1'b1;
                            end
                        end
                        else if (hit)
                        begin
                            state_reg <= S_DONE;
                            if (cmd_reg != CMD_ADD)
                            begin
                                res_ok_reg   <= 1'b1;
                                res_slot_reg <= chk_pos_reg;
                                wr_pend_reg  <= (cmd_reg == CMD_DELETE);
                            end
                        end
                        else if (chk_last_reg)
                        begin
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_RDWAIT:
                begin
                    if (rd_data_reg.valid)
                    begin
                        res_ok_reg   <= 1'b1;
                        res_slot_reg <= chk_pos_reg;
                        res_key_reg  <= rd_data_reg.key;
                        res_len_reg  <= rd_data_reg.len;
                    end
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_ok_reg   <= res_ok_reg;
                        out_slot_reg <= SLOT_OUT_W'(res_slot_reg);
                        out_key_reg  <= res_key_reg;
                        out_len_reg  <= res_len_reg;
                        out_cnt_reg  <= ENT_W'(count_next);
                        count_reg    <= count_next;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid       = out_vld_reg;
    assign rsp.ok          = out_ok_reg;
    assign rsp.slot        = out_slot_reg;
    assign rsp.key_out     = out_key_reg;
    assign rsp.key_len_out = out_len_reg;
    assign rsp.entry_count = out_cnt_reg;

endmodule

`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for the quadratic probing hash table.
`timescale 1ns / 100ps

module tb;
    import qph_pkg::*;

    localparam int TABLE_SLOTS  = TABLE_SLOTS_DEF;
    localparam int PROBE_LIMIT  = PROBE_LIMIT_DEF;
    localparam int KEY_BYTES    = KEY_BYTES_DEF;
    localparam int POOL_SIZE    = 128;
    localparam int CLUSTER_KEYS = 22;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int SETTLE_CYCLES = 60;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int REPORT_LINES = 40;

    typedef struct packed {
        logic                  ok;
        logic [SLOT_OUT_W-1:0] slot;
        logic [KEY_W-1:0]      key_out;
        logic [LEN_W-1:0]      key_len_out;
        logic [ENT_W-1:0]      entry_count;
    } table_reply_t;

    class hash_table_scoreboard;
        bit               occupied [TABLE_SLOTS];
        logic [KEY_W-1:0] stored_key [TABLE_SLOTS];
        int               stored_len [TABLE_SLOTS];
        int               live_entries;
        table_reply_t     pending_replies [$];
        int               errors;
        int               replies_seen;
        int               inserts, duplicate_adds, full_adds, removals;
        int               hits, misses, valid_reads, peak_entries;

        function int home_of(logic [KEY_W-1:0] key, int len);
            int sum;
            sum = 0;
            for (int i = 0; i < len; i++)
                sum += key[8*i +: 8] * (i + 1);
            return (sum * HASH_MUL) % TABLE_SLOTS;
        endfunction

        function int probe_at(int home, int j);
            return (home + j * j + PROBE_LIN * j) % TABLE_SLOTS;
        endfunction

        function int search(logic [KEY_W-1:0] key, int len);
            int home;
            int s;
            home = home_of(key, len);
            for (int j = 0; j < PROBE_LIMIT; j++) begin
                s = probe_at(home, j);
                if (!occupied[s])
                    return -1;
                if (stored_len[s] == len && stored_key[s] == key)
                    return s;
            end
            return -1;
        endfunction

        function void apply_request(cmd_t cmd, logic [KEY_W-1:0] chars,
                                    logic [LEN_W-1:0] len_field, logic [IDX_W-1:0] idx);
            int               len;
            int               s;
            int               home;
            logic [KEY_W-1:0] key;
            table_reply_t     r;
            len = (len_field > KEY_BYTES) ? KEY_BYTES : int'(len_field);
            key = '0;
            for (int i = 0; i < len; i++)
                key[8*i +: 8] = chars[8*i +: 8];
            r = '0;
            case (cmd)
                CMD_ADD: begin
                    if (search(key, len) >= 0) begin
                        duplicate_adds++;
                    end
                    else begin
                        home = home_of(key, len);
                        s = -1;
                        for (int j = 0; j < PROBE_LIMIT && s < 0; j++)
                            if (!occupied[probe_at(home, j)])
                                s = probe_at(home, j);
                        if (s < 0) begin
                            full_adds++;
                        end
                        else begin
                            occupied[s] = 1'b1;
                            stored_key[s] = key;
                            stored_len[s] = len;
                            live_entries++;
                            r.ok = 1'b1;
                            r.slot = SLOT_OUT_W'(s);
                            inserts++;
                        end
                    end
                end
                CMD_DELETE: begin
                    s = search(key, len);
                    if (s >= 0) begin
                        occupied[s] = 1'b0;
                        live_entries--;
                        r.ok = 1'b1;
                        r.slot = SLOT_OUT_W'(s);
                        removals++;
                    end
                    else begin
                        misses++;
                    end
                end
                CMD_LOOKUP: begin
                    s = search(key, len);
                    if (s >= 0) begin
                        r.ok = 1'b1;
                        r.slot = SLOT_OUT_W'(s);
                        hits++;
                    end
                    else begin
                        misses++;
                    end
                end
                CMD_READ: begin
                    if (idx < TABLE_SLOTS) begin
                        if (occupied[idx]) begin
                            r.ok = 1'b1;
                            r.slot = idx;
                            r.key_out = stored_key[idx];
                            r.key_len_out = LEN_W'(stored_len[idx]);
                            valid_reads++;
                        end
                    end
                end
            endcase
            r.entry_count = ENT_W'(live_entries);
            if (live_entries > peak_entries)
                peak_entries = live_entries;
            pending_replies.push_back(r);
        endfunction

        task report(string what);
            errors++;
            if (errors <= REPORT_LINES)
                $display("%0t reply %0d mismatch: %s", $time, replies_seen, what);
        endtask

        task compare_reply(table_reply_t got);
            table_reply_t want;
            replies_seen++;
            if (pending_replies.size() == 0) begin
                report("reply with no request outstanding");
                return;
            end
            want = pending_replies.pop_front();
            if (got.ok !== want.ok)
                report($sformatf("ok %b, want %b", got.ok, want.ok));
            if (got.slot !== want.slot)
                report($sformatf("slot %0d, want %0d", got.slot, want.slot));
            if (got.key_out !== want.key_out)
                report($sformatf("key_out %h, want %h", got.key_out, want.key_out));
            if (got.key_len_out !== want.key_len_out)
                report($sformatf("key_len_out %0d, want %0d", got.key_len_out,
                                 want.key_len_out));
            if (got.entry_count !== want.entry_count)
                report($sformatf("entry_count %0d, want %0d", got.entry_count,
                                 want.entry_count));
        endtask
    endclass

    logic clk;
    logic rst_n;

    qph_in_if  req_if ();
    qph_out_if rsp_if ();

    quadratic_probe_hash_table DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    hash_table_scoreboard sb;
    logic [KEY_W-1:0]     pool_key [POOL_SIZE];
    int                   pool_len [POOL_SIZE];
    int                   tx_idle_pct;
    int                   rx_idle_pct;
    int                   hold_cycles;
    int                   cycle_count;

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                rsp_if.ready <= 1'b0;
            end
            else begin
                rsp_if.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
            sb.compare_reply({rsp_if.ok, rsp_if.slot, rsp_if.key_out,
                              rsp_if.key_len_out, rsp_if.entry_count});
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d replies outstanding", cycle_count,
                     sb.pending_replies.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic [KEY_W-1:0] low_bytes(int len);
        return (len >= KEY_BYTES) ? '1 : ((KEY_W'(1) << (8 * len)) - 1);
    endfunction

    task automatic send(cmd_t cmd, logic [KEY_W-1:0] chars, logic [LEN_W-1:0] len,
                        logic [IDX_W-1:0] idx);
        while ($urandom_range(99) < tx_idle_pct) begin
            @(negedge clk);
            req_if.valid <= 1'b0;
        end
        @(negedge clk);
        req_if.valid      <= 1'b1;
        req_if.cmd        <= cmd;
        req_if.key_chars  <= chars;
        req_if.key_len    <= len;
        req_if.slot_index <= idx;
        do
            @(posedge clk);
        while (req_if.ready !== 1'b1);
        sb.apply_request(cmd, chars, len, idx);
    endtask

    task automatic send_key(cmd_t cmd, int p);
        logic [KEY_W-1:0] chars;
        logic [LEN_W-1:0] len;
        chars = pool_key[p];
        len = LEN_W'(pool_len[p]);
        if ($urandom_range(1) == 1)
            chars |= {$urandom, $urandom} & ~low_bytes(pool_len[p]);
        if (pool_len[p] == KEY_BYTES && $urandom_range(1) == 1)
            len = LEN_W'($urandom_range(KEY_BYTES, 15));
        send(cmd, chars, len, IDX_W'($urandom_range(127)));
    endtask

    task automatic refresh_pool(int p, bit only_if_absent);
        if (!only_if_absent || sb.search(pool_key[p], pool_len[p]) < 0) begin
            pool_len[p] = $urandom_range(0, KEY_BYTES);
            pool_key[p] = {$urandom, $urandom} & low_bytes(pool_len[p]);
        end
    endtask

    task automatic send_read();
        logic [IDX_W-1:0] idx;
        idx = ($urandom_range(9) == 0) ? IDX_W'($urandom_range(TABLE_SLOTS, 127))
                                       : IDX_W'($urandom_range(TABLE_SLOTS - 1));
        send(CMD_READ, {$urandom, $urandom}, LEN_W'($urandom_range(15)), idx);
    endtask

    // Two-byte keys sharing one byte-weighted sum, so they share one home slot.
    task automatic add_cluster();
        int               total;
        int               hi_base;
        int               p;
        logic [KEY_W-1:0] key;
        total = $urandom_range(200, 300);
        hi_base = $urandom_range(23, 78);
        p = $urandom_range(POOL_SIZE - 1);
        for (int k = 0; k < CLUSTER_KEYS; k++) begin
            key = '0;
            key[15:8] = 8'(hi_base + k);
            key[7:0] = 8'(total - 2 * (hi_base + k));
            if (sb.search(pool_key[(p + k) % POOL_SIZE], pool_len[(p + k) % POOL_SIZE]) < 0)
            begin
                pool_key[(p + k) % POOL_SIZE] = key;
                pool_len[(p + k) % POOL_SIZE] = 2;
            end
            send(CMD_ADD, key | ({$urandom, $urandom} & ~low_bytes(2)), LEN_W'(2),
                 IDX_W'($urandom_range(127)));
        end
    endtask

    task automatic run_random(int count);
        int n;
        int r;
        int p;
        int bias;
        int add_w;
        int del_w;
        int look_w;
        n = 0;
        while (n < count) begin
            bias = (n / 120) % 3;
            case (bias)
                0: begin add_w = 55; del_w = 10; look_w = 20; end
                1: begin add_w = 30; del_w = 30; look_w = 25; end
                default: begin add_w = 10; del_w = 55; look_w = 20; end
            endcase
            r = $urandom_range(99);
            p = $urandom_range(POOL_SIZE - 1);
            if (bias == 0 && r < 2) begin
                add_cluster();
                n += CLUSTER_KEYS;
            end
            else begin
                if (r < 6) begin
                    send(cmd_t'($urandom_range(3)), {$urandom, $urandom},
                         LEN_W'($urandom_range(15)), IDX_W'($urandom_range(127)));
                end
                else if (r < 6 + add_w) begin
                    if ($urandom_range(4) == 0)
                        refresh_pool(p, 1'b1);
                    send_key(CMD_ADD, p);
                end
                else if (r < 6 + add_w + del_w) begin
                    send_key(CMD_DELETE, p);
                end
                else if (r < 6 + add_w + del_w + look_w) begin
                    send_key(CMD_LOOKUP, p);
                end
                else begin
                    send_read();
                end
                n++;
            end
        end
    endtask

    task automatic wait_all_replies();
        @(negedge clk);
        req_if.valid <= 1'b0;
        while (sb.pending_replies.size() != 0)
            @(posedge clk);
    endtask

    initial begin
        sb = new();
        cycle_count = 0;
        hold_cycles = 0;
        tx_idle_pct = 21;
        rx_idle_pct = 77;
        rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.cmd = CMD_ADD;
        req_if.key_chars = '0;
        req_if.key_len = '0;
        req_if.slot_index = '0;
        for (int p = 0; p < POOL_SIZE; p++)
            refresh_pool(p, 1'b0);
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send(CMD_LOOKUP, 64'h0, 4'd0, 7'd0);
        send(CMD_DELETE, '1, 4'd8, 7'd0);
        send(CMD_READ, 64'h0, 4'd0, 7'd0);
        send(CMD_READ, 64'h0, 4'd0, 7'd127);
        send(CMD_READ, '1, 4'd15, 7'd101);
        send(CMD_ADD, 64'hDEAD_BEEF_0BAD_F00D, 4'd0, 7'd0);
        send(CMD_ADD, '1, 4'd8, 7'd0);
        send(CMD_ADD, '1, 4'd15, 7'd0);
        send(CMD_ADD, 64'h0, 4'd1, 7'd0);
        send(CMD_ADD, 64'hA5A5_A5A5_A512_3456, 4'd3, 7'd0);
        send(CMD_LOOKUP, 64'h5A5A_5A5A_5A12_3456, 4'd3, 7'd0);
        send(CMD_LOOKUP, 64'h0000_0000_0012_3456, 4'd4, 7'd0);
        send(CMD_READ, 64'h0, 4'd0, 7'd0);
        send(CMD_READ, 64'h0, 4'd0, IDX_W'(sb.search('1, KEY_BYTES)));
        send(CMD_DELETE, 64'hFFFF, 4'd0, 7'd0);
        send(CMD_LOOKUP, 64'h0, 4'd1, 7'd0);
        send(CMD_ADD, 64'h0000_0000_0012_3456, 4'd3, 7'd0);
        send(CMD_ADD, 64'hAAAA_AAAA_AAAA_AAAA, 4'd12, 7'd0);
        send(CMD_ADD, 64'h5555_5555_5555_5555, 4'd9, 7'd0);
        send(CMD_READ, 64'h0, 4'd0, IDX_W'(sb.search(64'h5555_5555_5555_5555, KEY_BYTES)));
        send(CMD_DELETE, 64'hAAAA_AAAA_AAAA_AAAA, 4'd8, 7'd0);
        send(CMD_LOOKUP, '1, 4'd8, 7'd127);
        wait_all_replies();

        run_random(600);
        wait_all_replies();

        tx_idle_pct = 77;
        rx_idle_pct = 21;
        run_random(600);
        wait_all_replies();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random(300);
        hold_cycles = HOLD_OFF_CYCLES;
        run_random(300);
        wait_all_replies();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("checked %0d replies: %0d inserts, %0d duplicate adds, %0d adds with no free slot",
                 sb.replies_seen, sb.inserts, sb.duplicate_adds, sb.full_adds);
        $display("%0d removals, %0d hits, %0d misses, %0d valid slot reads, peak of %0d entries",
                 sb.removals, sb.hits, sb.misses, sb.valid_reads, sb.peak_entries);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
